// ===== sv/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: condition does not hold");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/cssc_pkg.sv =====
// shared constants and classification function for the color sensor sequencer
package cssc_pkg;

    // widths
    localparam int ELAPSED_BITS_DEF = 32;
    localparam int COUNTS_W         = 16;
    localparam int NUM_W            = 26;
    localparam int CODE_W           = 2;
    localparam int CFG_INDEX_W      = 2;

    // frequency arithmetic
    localparam logic [NUM_W-1:0] FREQ_MUL = NUM_W'(1000);
    localparam logic [NUM_W-1:0] FREQ_MAX = NUM_W'(65535000);

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_COUNTS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FREQ_SCALE    = 2'd1;

    // filter channel codes
    localparam logic [CODE_W-1:0] CH_RED   = 2'd0;
    localparam logic [CODE_W-1:0] CH_BLUE  = 2'd1;
    localparam logic [CODE_W-1:0] CH_CLEAR = 2'd2;
    localparam logic [CODE_W-1:0] CH_GREEN = 2'd3;

    // class codes
    localparam logic [CODE_W-1:0] CLASS_NONE   = 2'd0;
    localparam logic [CODE_W-1:0] CLASS_BLUE   = 2'd1;
    localparam logic [CODE_W-1:0] CLASS_RED    = 2'd2;
    localparam logic [CODE_W-1:0] CLASS_PURPLE = 2'd3;

    // scale reset value: full scale
    localparam logic [CODE_W-1:0] SCALE_FULL = 2'd3;

    // classification thresholds
    localparam logic [NUM_W-1:0] BLUE_MIN_BLUE  = NUM_W'(60);
    localparam logic [NUM_W-1:0] BLUE_MAX_RED   = NUM_W'(20);
    localparam logic [NUM_W-1:0] RED_MIN_RED    = NUM_W'(35);
    localparam logic [NUM_W-1:0] RED_MAX_RED    = NUM_W'(50);
    localparam logic signed [NUM_W:0] RED_MAX_DIFF = (NUM_W+1)'(15);
    localparam logic [NUM_W-1:0] PUR_MIN_RED    = NUM_W'(10);
    localparam logic [NUM_W-1:0] PUR_MAX_RED    = NUM_W'(30);
    localparam logic signed [NUM_W:0] PUR_MIN_DIFF = (NUM_W+1)'(20);

    // first matching rule wins: blue, then red, then purple
    function automatic logic [CODE_W-1:0] classify(
        input logic [NUM_W-1:0] red,
        input logic [NUM_W-1:0] blue
    );
        logic signed [NUM_W:0] diff;
        logic [CODE_W-1:0]     cls;
        diff = $signed({1'b0, blue}) - $signed({1'b0, red});
        if (blue > BLUE_MIN_BLUE && red < BLUE_MAX_RED)
            cls = CLASS_BLUE;
        else if (red > RED_MIN_RED && red < RED_MAX_RED && diff < RED_MAX_DIFF)
            cls = CLASS_RED;
        else if (red > PUR_MIN_RED && red < PUR_MAX_RED && diff > PUR_MIN_DIFF)
            cls = CLASS_PURPLE;
        else
            cls = CLASS_NONE;
        return cls;
    endfunction

endpackage

// ===== sv/color_sensor_sequencer_classifier.sv =====
// top level: sequencer, channel stores, classifier and output register
// Each accepted request is one finished sensor window; the block computes
// window_counts*1000/elapsed_us rounded down (65535000 for zero elapsed),
// stores it for the current filter channel, steps red, blue, green and
// reports the stored levels, the pin codes and the class. After acceptance
// a request passes through the start, divide and finish states before the
// next request can be accepted (divide is skipped when elapsed_us is zero);
// the shared restoring divider produces one of the 26 quotient bits per cycle.
// A finished result waits in the output register while the next request is
// taken; the result of that request is held back until the first is taken.
`include "assert_macros.svh"

module color_sensor_sequencer_classifier
    import cssc_pkg::*;
#(
    parameter int ELAPSED_BITS = ELAPSED_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration write port
    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [COUNTS_W-1:0]     cfg_data,
    // request channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [ELAPSED_BITS-1:0] elapsed_us,
    // result channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [CODE_W-1:0]       measured_channel,
    output logic [NUM_W-1:0]        measured_freq,
    output logic [NUM_W-1:0]        red_level,
    output logic [NUM_W-1:0]        blue_level,
    output logic [NUM_W-1:0]        green_level,
    output logic [CODE_W-1:0]       filter_pins,
    output logic [CODE_W-1:0]       scale_pins,
    output logic [CODE_W-1:0]       ball_class
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_FIN
    } state_t;

    state_t                  state_reg;
    logic [COUNTS_W-1:0]     window_counts_reg;
    logic [CODE_W-1:0]       freq_scale_reg;
    logic [CODE_W-1:0]       channel_reg;
    logic [NUM_W-1:0]        red_store_reg;
    logic [NUM_W-1:0]        blue_store_reg;
    logic [NUM_W-1:0]        green_store_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [ELAPSED_BITS-1:0] den_reg;
    logic [NUM_W-1:0]        freq_reg;
    logic                    out_valid_reg;
    logic [CODE_W-1:0]       meas_channel_reg;
    logic [NUM_W-1:0]        meas_freq_reg;

    logic             accept;
    logic             out_free;
    logic             fin_load;
    logic             div_start;
    logic             div_done;
    logic [NUM_W-1:0] div_quot;
    logic [NUM_W-1:0] num_next;

    // handshake decode
    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign fin_load  = (state_reg == S_FIN) && out_free;
    // divider only runs for a nonzero elapsed time
    assign div_start = (state_reg == S_START) && (den_reg != '0);

    // numerator scaled by 1000
    assign num_next = NUM_W'(window_counts_reg) * FREQ_MUL;

    // shared divider
    cssc_divider #(
        .ELAPSED_BITS (ELAPSED_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (num_reg),
        .denom (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_counts_reg <= '0;
            freq_scale_reg    <= SCALE_FULL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW_COUNTS: window_counts_reg <= cfg_data;
                REG_FREQ_SCALE:    freq_scale_reg    <= cfg_data[CODE_W-1:0];
                default:           ;
            endcase
        end
    end

    // operands latched on acceptance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            num_reg <= num_next;
            den_reg <= elapsed_us;
        end
    end

    // sequencer, channel stores and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            channel_reg      <= CH_RED;
            red_store_reg    <= '0;
            blue_store_reg   <= '0;
            green_store_reg  <= '0;
            out_valid_reg    <= 1'b0;
            freq_reg         <= '0;
            meas_channel_reg <= CH_RED;
            meas_freq_reg    <= '0;
        end
        else
        begin
            // result taken downstream
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                        state_reg <= S_START;
                end
                S_START:
                begin
                    // zero elapsed saturates without using the divider
                    if (den_reg == '0)
                    begin
                        freq_reg  <= FREQ_MAX;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        freq_reg  <= div_quot;
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        unique case (channel_reg)
                            CH_RED:
                            begin
                                red_store_reg <= freq_reg;
                                channel_reg   <= CH_BLUE;
                            end
                            CH_BLUE:
                            begin
                                blue_store_reg <= freq_reg;
                                channel_reg    <= CH_GREEN;
                            end
                            CH_GREEN:
                            begin
                                green_store_reg <= freq_reg;
                                channel_reg     <= CH_RED;
                            end
                            default:
                            begin
                                // clear channel: nothing stored, channel holds
                            end
                        endcase
                        meas_channel_reg <= channel_reg;
                        meas_freq_reg    <= freq_reg;
                        out_valid_reg    <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // result outputs; stores only move when the output register loads
    assign out_valid        = out_valid_reg;
    assign measured_channel = meas_channel_reg;
    assign measured_freq    = meas_freq_reg;
    assign red_level        = red_store_reg;
    assign blue_level       = blue_store_reg;
    assign green_level      = green_store_reg;
    assign filter_pins      = channel_reg;
    assign scale_pins       = freq_scale_reg;
    assign ball_class       = classify(red_store_reg, blue_store_reg);

    // checks
    `ASSERT_IMPLIES(a_done_in_div, clk, rst_n, div_done, state_reg == S_DIV)
    `ASSERT_ALWAYS(a_never_clear, clk, rst_n, channel_reg != CH_CLEAR)
    `ASSERT_NEXT(a_result_loads, clk, rst_n, fin_load, out_valid_reg && (state_reg == S_IDLE))
    `ASSERT_NEXT(a_meas_channel, clk, rst_n, fin_load, meas_channel_reg == $past(channel_reg))

endmodule

// ===== sv/cssc_divider.sv =====
// restoring divider, one quotient bit per cycle
module cssc_divider
    import cssc_pkg::*;
#(
    parameter int ELAPSED_BITS = ELAPSED_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [NUM_W-1:0]        numer,
    input  logic [ELAPSED_BITS-1:0] denom,
    output logic                    done,
    output logic [NUM_W-1:0]        quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int CMP_W = (ELAPSED_BITS > NUM_W) ? ELAPSED_BITS : NUM_W + 1;

    logic                    busy_reg;
    logic                    done_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [NUM_W-1:0]        rem_reg;
    logic [ELAPSED_BITS-1:0] den_reg;

    logic [NUM_W:0]   shifted;
    logic [CMP_W-1:0] cmp_a;
    logic [CMP_W-1:0] cmp_b;
    logic [CMP_W-1:0] diff;
    logic             fits;
    logic [NUM_W-1:0] rem_next;
    logic [NUM_W-1:0] num_next;

    // one subtract and compare step
    always_comb
    begin
        shifted  = {rem_reg, num_reg[NUM_W-1]};
        cmp_a    = CMP_W'(shifted);
        cmp_b    = CMP_W'(den_reg);
        diff     = cmp_a - cmp_b;
        fits     = (cmp_a >= cmp_b);
        rem_next = fits ? diff[NUM_W-1:0] : shifted[NUM_W-1:0];
        num_next = {num_reg[NUM_W-2:0], fits};
    end

    // control: step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath: dividend shifts out, quotient shifts in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= numer;
            den_reg <= denom;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule
